FILE: hw/rtl/pwpt_pkg.sv
package pwpt_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int IDX_WIDTH   = 6;
   localparam int CNT_WIDTH   = 7;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [1:0] REG_VERTEX_COUNT = 2'd0;

   typedef struct packed {
      logic                          op;
      logic [IDX_WIDTH-1:0]          vertex_index;
      logic signed [COORD_WIDTH-1:0] coord_x;
      logic signed [COORD_WIDTH-1:0] coord_y;
   } req_type;

   typedef struct packed {
      logic inside_res;
      logic coincident_error;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x;
      logic signed [COORD_WIDTH-1:0] y;
   } vertex_type;

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } edge_cmd_type;

endpackage

FILE: hw/rtl/pwpt_cell.sv
module pwpt_cell
   import pwpt_pkg::*;
(
   input  logic       clock,
   input  logic       load,
   input  logic       shift,
   input  vertex_type load_data,
   input  vertex_type shift_data,
   output vertex_type vertex
);

   vertex_type vertex_ff;
   vertex_type vertex_in;

   always_comb begin
      vertex_in = vertex_ff;
      if (load) begin
         vertex_in = load_data;
      end else if (shift) begin
         vertex_in = shift_data;
      end
   end

   always_ff @(posedge clock) begin
      vertex_ff <= vertex_in;
   end

   assign vertex = vertex_ff;

endmodule

FILE: hw/rtl/pwpt_edge.sv
module pwpt_edge
   import pwpt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  edge_cmd_type cmd,
   input  vertex_type   point,
   input  vertex_type   vert_a,
   input  vertex_type   vert_b,
   output logic         done,
   output logic         odd_winding
);

   localparam int DW = COORD_WIDTH + 1;
   localparam int PW = 2 * DW;

   function automatic logic [1:0] quadrant(vertex_type p, vertex_type v);
      logic [1:0] q;
      if (v.x > p.x && v.y >= p.y) begin
         q = 2'd0;
      end else if (v.x <= p.x && v.y > p.y) begin
         q = 2'd1;
      end else if (v.x < p.x && v.y <= p.y) begin
         q = 2'd2;
      end else begin
         q = 2'd3;
      end
      return q;
   endfunction

   edge_cmd_type s1_ff, s2_ff;
   logic [1:0] d1_ff, d2_ff;
   logic signed [DW-1:0] dxa_ff, dya_ff, dxb_ff, dyb_ff;
   logic signed [PW-1:0] p1_ff, p2_ff;
   logic [2:0] sum_ff, sum_in, base, inc;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
         s2_ff <= '0;
      end else begin
         s1_ff <= cmd;
         s2_ff <= s1_ff;
      end
   end

   // stage 1: offsets and quadrant turn; stage 2: cross products
   always_ff @(posedge clock) begin
      d1_ff  <= quadrant(point, vert_b) - quadrant(point, vert_a);
      dxa_ff <= DW'(vert_a.x) - DW'(point.x);
      dya_ff <= DW'(vert_a.y) - DW'(point.y);
      dxb_ff <= DW'(vert_b.x) - DW'(point.x);
      dyb_ff <= DW'(vert_b.y) - DW'(point.y);
      d2_ff  <= d1_ff;
      p1_ff  <= dxa_ff * dyb_ff;
      p2_ff  <= dxb_ff * dya_ff;
   end

   // only bit 2 of the winding sum matters, so keep it modulo eight
   always_comb begin
      base = s2_ff.first ? 3'd0 : sum_ff;
      unique case (d2_ff)
         2'd0: inc = 3'd0;
         2'd1: inc = 3'd1;
         2'd2: inc = (p1_ff > p2_ff) ? 3'd2 : 3'd6;
         2'd3: inc = 3'd7;
         default: inc = 3'd0;
      endcase
      sum_in = base + inc;
   end

   always_ff @(posedge clock) begin
      if (s2_ff.valid) begin
         sum_ff <= sum_in;
      end
   end

   assign done        = s2_ff.valid && s2_ff.last;
   assign odd_winding = sum_in[2];

endmodule

FILE: hw/rtl/polygon_winding_point_test_core.sv
// Point-in-polygon test by quadrant winding number.
// Input channel (req_): op OP_WRITE stores one vertex at vertex_index; op OP_QUERY
// tests the point (coord_x, coord_y) against the first vertex_count vertices.
// A write gives no result; one is accepted every cycle while idle.
// A query rotates the vertex ring of MAX_VERTICES cells once, one vertex per cycle,
// feeding the edge unit; its result is loaded into the output register once the ring
// has rotated back into place and the last edge has left the edge unit, so queries
// run one at a time.
// Result channel (rsp_): inside_res, and coincident_error when the point equals a
// vertex in use (inside_res is then 0). The result waits in the output register
// while rsp_stall is high; a query that finishes meanwhile holds until it is taken.
// req_stall is high while a query is in progress.
// CSR port: register 0 is vertex_count (reset 3), clamped to 3..MAX_VERTICES on use.
// Reset clears control state and sets vertex_count to 3; vertex storage is undefined
// until written.
module polygon_winding_point_test_core
   import pwpt_pkg::*;
#(
   parameter int MAX_VERTICES = 64
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [1:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);

   localparam int NW = $clog2(MAX_VERTICES + 1);
   localparam int EW = (NW > CNT_WIDTH) ? NW : CNT_WIDTH;
   localparam logic [NW-1:0] N_MAX = NW'(MAX_VERTICES);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic                 state_ff, state_in;
   logic [NW-1:0]        step_ff, step_in;
   logic [CNT_WIDTH-1:0] count_ff;
   vertex_type           point_ff, v0_ff, prev_ff;
   logic                 hit_ff, hit_in;
   logic                 seen_ff, inside_ff;
   logic                 shifted_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;

   logic       req_accept, wr_en, start, shift, finish, csr_write;
   logic [EW-1:0] cnt_ext;
   logic [NW-1:0] n_eff;
   vertex_type    ring_q [MAX_VERTICES];
   vertex_type    head, req_vertex;
   edge_cmd_type  cmd;
   vertex_type    vert_b;
   logic          edge_done, edge_inside;

   // csr: single register, any address of the port selects it
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && ((csr_paddr >> 2) == REG_VERTEX_COUNT);
   assign csr_prdata = 32'(count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CNT_WIDTH'(3);
      end else if (csr_write) begin
         count_ff <= csr_pwdata[CNT_WIDTH-1:0];
      end
   end

   always_comb begin
      cnt_ext = EW'(count_ff);
      if (cnt_ext < EW'(3)) begin
         n_eff = NW'(3);
      end else if (cnt_ext > EW'(MAX_VERTICES)) begin
         n_eff = N_MAX;
      end else begin
         n_eff = NW'(cnt_ext);
      end
   end

   assign req_stall  = (state_ff == ST_RUN);
   assign req_accept = req_valid && !req_stall;
   assign wr_en      = req_accept && (req_data.op == OP_WRITE);
   assign start      = req_accept && (req_data.op == OP_QUERY);
   assign req_vertex = '{x: req_data.coord_x, y: req_data.coord_y};

   assign shift = (state_ff == ST_RUN) && (step_ff < N_MAX);
   assign head  = ring_q[0];

   // ring: cell i takes from cell i+1, so vertex k reaches the head at step k
   for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_ring
      localparam int NEXT = (i + 1) % MAX_VERTICES;
      pwpt_cell u_cell (
         .clock      (clock),
         .load       (wr_en && (32'(req_data.vertex_index) == 32'(i))),
         .shift      (shift),
         .load_data  (req_vertex),
         .shift_data (ring_q[NEXT]),
         .vertex     (ring_q[i])
      );
   end

   // issue each edge once, in the cycle after the shift that brought its end vertex
   always_comb begin
      cmd.valid = (state_ff == ST_RUN) && shifted_ff && (step_ff != '0)
                  && (step_ff <= n_eff);
      cmd.first = (step_ff == NW'(1));
      cmd.last  = (step_ff == n_eff);
      vert_b    = (step_ff == n_eff) ? v0_ff : head;
   end

   pwpt_edge u_edge (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .point       (point_ff),
      .vert_a      (prev_ff),
      .vert_b      (vert_b),
      .done        (edge_done),
      .odd_winding (edge_inside)
   );

   assign finish = (state_ff == ST_RUN) && (step_ff == N_MAX) && seen_ff
                   && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      hit_in   = hit_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_RUN;
               step_in  = '0;
               hit_in   = 1'b0;
            end
         end
         ST_RUN: begin
            if (step_ff < n_eff && head == point_ff) begin
               hit_in = 1'b1;
            end
            if (shift) begin
               step_in = step_ff + NW'(1);
            end
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         hit_ff       <= 1'b0;
         seen_ff      <= 1'b0;
         shifted_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         step_ff    <= step_in;
         hit_ff     <= hit_in;
         shifted_ff <= shift;
         if (start) begin
            seen_ff <= 1'b0;
         end else if (edge_done) begin
            seen_ff <= 1'b1;
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      prev_ff <= head;
      if (start) begin
         point_ff <= req_vertex;
      end
      if (state_ff == ST_RUN && step_ff == '0) begin
         v0_ff <= head;
      end
      if (edge_done) begin
         inside_ff <= edge_inside;
      end
      if (finish) begin
         rsp_data_ff.inside_res       <= inside_ff && !hit_ff;
         rsp_data_ff.coincident_error <= hit_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      edge_done |-> state_ff == ST_RUN)
      else $error("edge unit finished outside a query");
   a_finish_aligned: assert property (@(posedge clock) disable iff (reset)
      finish |-> step_ff == N_MAX && !shift)
      else $error("result loaded before the ring realigned");
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> req_stall)
      else $error("query did not stall the input");
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.inside_res && rsp_data.coincident_error))
      else $error("inside and coincident both set");
`endif

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps

module tb;
   import pwpt_pkg::*;

   localparam int NVERT = 64;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES = NVERT + 20;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [1:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   polygon_winding_point_test_core #(.MAX_VERTICES(NVERT)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // polygon mirror and expected verdicts
   logic signed [COORD_WIDTH-1:0] poly_x [NVERT];
   logic signed [COORD_WIDTH-1:0] poly_y [NVERT];
   logic [CNT_WIDTH-1:0] poly_count;
   req_type pending_items [$];
   rsp_type expected_verdicts [$];
   int mismatches;
   int gap_max;
   int idle_cycles;
   int items_queued;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int quadrant_of(int px, int py, int nx, int ny);
      if (nx > px && ny >= py) return 0;
      if (nx <= px && ny > py) return 1;
      if (nx < px && ny <= py) return 2;
      return 3;
   endfunction

   function automatic void apply_item(req_type r);
      int n, i, j, px, py, qa, qb, d;
      longint det;
      logic [31:0] winding;
      bit hit;
      rsp_type v;
      if (r.op == OP_WRITE) begin
         poly_x[r.vertex_index] = r.coord_x;
         poly_y[r.vertex_index] = r.coord_y;
         return;
      end
      n = poly_count;
      if (n < 3) n = 3;
      if (n > NVERT) n = NVERT;
      px = r.coord_x;
      py = r.coord_y;
      hit = 0;
      winding = '0;
      for (i = 0; i < n; i++)
         if (poly_x[i] == r.coord_x && poly_y[i] == r.coord_y) hit = 1;
      for (i = 0; i < n; i++) begin
         j = (i + 1 == n) ? 0 : i + 1;
         qa = quadrant_of(px, py, poly_x[i], poly_y[i]);
         qb = quadrant_of(px, py, poly_x[j], poly_y[j]);
         d = (qb - qa) & 3;
         if (d == 1) winding = winding + 1;
         else if (d == 3) winding = winding - 1;
         else if (d == 2) begin
            det = longint'(int'(poly_x[i]) - px) * longint'(int'(poly_y[j]) - py)
                - longint'(int'(poly_x[j]) - px) * longint'(int'(poly_y[i]) - py);
            winding = (det > 0) ? winding + 2 : winding - 2;
         end
      end
      v.coincident_error = hit;
      v.inside_res = hit ? 1'b0 : winding[2];
      expected_verdicts = {expected_verdicts, v};
   endfunction

   // driver: one transfer per accepted item, random gap afterwards
   int gap_left;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
         gap_left = 0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) apply_item(req_data);
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            req_data  <= pending_items.pop_front();
            req_valid <= 1'b1;
            gap_left = $urandom_range(0, gap_max);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: compare each result transfer, stall at random
   int stall_left;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_verdicts.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: inside=%0b coincident=%0b",
                           rsp_data.inside_res, rsp_data.coincident_error);
            end else begin
               rsp_type e;
               e = expected_verdicts.pop_front();
               if (e.inside_res !== rsp_data.inside_res ||
                   e.coincident_error !== rsp_data.coincident_error) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected inside=%0b coincident=%0b, got %0b %0b",
                              e.inside_res, e.coincident_error,
                              rsp_data.inside_res, rsp_data.coincident_error);
               end
            end
            stall_left = $urandom_range(0, gap_max);
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left != 0);
      end
   end

   // watchdog on transfers of any kind
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable))
         idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_items.size() != 0 || expected_verdicts.size() != 0 || req_valid);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_vertex_count(int value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= REG_VERTEX_COUNT;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_pwdata  <= $urandom;
      poly_count = value[CNT_WIDTH-1:0];
   endtask

   task automatic push_item(logic op, int slot, int x, int y);
      req_type r;
      r.op           = op;
      r.vertex_index = slot[IDX_WIDTH-1:0];
      r.coord_x      = x[COORD_WIDTH-1:0];
      r.coord_y      = y[COORD_WIDTH-1:0];
      pending_items = {pending_items, r};
      items_queued++;
   endtask

   function automatic int pick_coord(int spread, int center);
      case ($urandom_range(0, 9))
         0: return -32768;
         1: return 32767;
         2, 3: return $urandom_range(0, 65535) - 32768;
         default: return center + $urandom_range(0, 2 * spread) - spread;
      endcase
   endfunction

   initial begin
      int n, k, spread, cx, cy, s;
      reset       = 1'b1;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      mismatches  = 0;
      gap_max     = 5;
      items_queued = 0;
      poly_count  = 3;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: square of side 20 around the origin, every slot filled at the extremes of the field
      write_vertex_count(4);
      for (k = 0; k < NVERT; k++) push_item(OP_WRITE, k, -32768, 32767);
      push_item(OP_WRITE, 0, -10, -10);
      push_item(OP_WRITE, 1, 10, -10);
      push_item(OP_WRITE, 2, 10, 10);
      push_item(OP_WRITE, 3, -10, 10);
      push_item(OP_QUERY, 63, 0, 0);          // inside
      push_item(OP_QUERY, 0, 20, 0);          // outside
      push_item(OP_QUERY, 5, 10, 10);         // on a vertex
      push_item(OP_QUERY, 0, 0, -10);         // on an edge, half turn with zero cross
      push_item(OP_QUERY, 0, 10, 0);
      push_item(OP_QUERY, 0, -32768, -32768);
      push_item(OP_QUERY, 0, 32767, 32767);
      wait_drained();
      // extreme triangle
      write_vertex_count(0);
      push_item(OP_WRITE, 0, -32768, -32768);
      push_item(OP_WRITE, 1, 32767, -32768);
      push_item(OP_WRITE, 2, 0, 32767);
      push_item(OP_QUERY, 0, 0, 0);
      push_item(OP_QUERY, 0, 32767, 32767);
      push_item(OP_QUERY, 0, -32768, 32767);
      push_item(OP_QUERY, 0, 0, -32768);
      wait_drained();
      write_vertex_count(127);                // all 64 filled slots
      push_item(OP_QUERY, 0, 0, 0);
      push_item(OP_QUERY, 0, -32768, 32767);
      wait_drained();

      // random polygons
      while (items_queued < 720) begin
         case ($urandom_range(0, 9))
            0: n = 127;
            1: n = 64;
            2: n = $urandom_range(0, 2);
            default: n = $urandom_range(3, 12);
         endcase
         gap_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
         write_vertex_count(n);
         if (n < 3) n = 3;
         if (n > NVERT) n = NVERT;
         spread = ($urandom_range(0, 1) == 0) ? 8 : 20000;
         cx = $urandom_range(0, 20000) - 10000;
         cy = $urandom_range(0, 20000) - 10000;
         for (k = 0; k < n; k++)
            push_item(OP_WRITE, k, pick_coord(spread, cx), pick_coord(spread, cy));
         for (k = 0; k < 8; k++) begin
            case ($urandom_range(0, 9))
               0: push_item(OP_WRITE, $urandom_range(0, NVERT - 1),
                            pick_coord(spread, cx), pick_coord(spread, cy));
               1: begin
                  s = $urandom_range(0, n - 1);
                  push_item(OP_QUERY, $urandom_range(0, NVERT - 1),
                            poly_x[s], poly_y[s]);
               end
               default: push_item(OP_QUERY, $urandom_range(0, NVERT - 1),
                                  pick_coord(spread, cx), pick_coord(spread, cy));
            endcase
         end
         wait_drained();
      end

      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
